// ===== rtl/fha_pkg.sv =====
package fha_pkg;

  localparam int ARENA_BYTES = 4096;
  localparam int HDR         = 2;
  localparam int SPLIT_MIN   = 3;
  localparam int BANK_DEPTH  = ARENA_BYTES / 2;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int LOC_W       = 18;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_NEG       = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_RANGE     = 3'd4,
    ST_DBL_FREE  = 3'd5,
    ST_BAD_START = 3'd6
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_SPLIT,
    S_NEVAL,
    S_DONE
  } fsm_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

// ===== rtl/fha_if.sv =====
interface fha_req_if;
  import fha_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [15:0] req_size;
  logic [15:0]        block_offset;
  modport source (output valid, op, req_size, block_offset, input ready);
  modport sink   (input valid, op, req_size, block_offset, output ready);
endinterface

interface fha_rsp_if;
  import fha_pkg::*;
  logic        valid;
  logic        ready;
  stat_t       status;
  logic [11:0] payload_offset;
  logic [11:0] largest_free;
  modport source (output valid, status, payload_offset, largest_free, input ready);
  modport sink   (input valid, status, payload_offset, largest_free, output ready);
endinterface

// ===== rtl/first_fit_heap_allocator.sv =====
// Channel | Dir | Word
// in_req  | in  | op, req_size, block_offset
// out_rsp | out | status, payload_offset, largest_free
//
// One request walks the block headers; each header visited is read (S_RD), then evaluated (S_EVAL).
// Early errors skip the walk and go straight to S_DONE.
// Rate is set by the single read port of the banked arena memory.
// rst_n is synchronous; the arena itself is not cleared, an init flag stands in.
// A new word is taken whenever the walker is idle, even while a result waits.
module first_fit_heap_allocator (
  input  logic clk,
  input  logic rst_n,
  fha_req_if.sink   in_req,
  fha_rsp_if.source out_rsp
);
  import fha_pkg::*;

  logic [7:0] bank_e [BANK_DEPTH];
  logic [7:0] bank_o [BANK_DEPTH];

  fsm_t               state_r, state_nxt;
  logic               init_r, init_nxt;
  logic               op_r;
  logic signed [15:0] size_r;
  logic [15:0]        addr_r;
  logic [LOC_W-1:0]   loc_r, loc_nxt;
  logic [11:0]        largest_r, largest_nxt;
  logic               prev_ok_r, prev_ok_nxt;
  logic [LOC_W-1:0]   prev_loc_r, prev_loc_nxt;
  logic signed [15:0] prev_v_r, prev_v_nxt;
  logic signed [15:0] v_r, v_nxt;
  logic               nxt_rd_r, nxt_rd_nxt;
  stat_t              res_st_r, res_st_nxt;
  logic [11:0]        res_pay_r, res_pay_nxt;
  logic [11:0]        res_lf_r, res_lf_nxt;
  logic               out_valid_r;
  stat_t              out_st_r;
  logic [11:0]        out_pay_r, out_lf_r;

  logic               rd_en, wr_en, rd_odd_r;
  logic [LOC_W-1:0]   rd_loc, wr_loc;
  logic [15:0]        wr_val;
  logic [7:0]         rd_e_r, rd_o_r;
  logic signed [15:0] rd_v;

  logic signed [LOC_W-1:0] v_s, mag, size_s, rem, nxt, merged, pv_new;
  logic                    in_fire;

  assign in_fire       = in_req.valid && in_req.ready;
  assign in_req.ready  = (state_r == S_IDLE);
  assign rd_v          = rd_odd_r ? signed'({rd_e_r, rd_o_r}) : signed'({rd_o_r, rd_e_r});

  // banked byte arena: a header at any offset is one read or one write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_odd_r <= rd_loc[0];
      rd_o_r   <= bank_o[rd_loc[BANK_AW:1]];
      rd_e_r   <= bank_e[rd_loc[BANK_AW:1] + BANK_AW'(rd_loc[0])];
    end
    if (wr_en) begin
      if (wr_loc[0]) begin
        bank_o[wr_loc[BANK_AW:1]]                  <= wr_val[7:0];
        bank_e[wr_loc[BANK_AW:1] + BANK_AW'(1'b1)] <= wr_val[15:8];
      end else begin
        bank_e[wr_loc[BANK_AW:1]] <= wr_val[7:0];
        bank_o[wr_loc[BANK_AW:1]] <= wr_val[15:8];
      end
    end
  end

  always_comb begin
    v_s    = LOC_W'(rd_v);
    mag    = v_s[LOC_W-1] ? -v_s : v_s;
    size_s = LOC_W'(size_r);
    rem    = mag - size_s;
    nxt    = loc_r + LOC_W'(HDR) + mag;
    merged = LOC_W'(v_r);
    if (nxt_rd_r && rd_v < 0) merged = merged + LOC_W'(HDR) - v_s;
    pv_new = LOC_W'(prev_v_r) - merged - LOC_W'(HDR);
  end

  always_comb begin
    state_nxt    = state_r;
    init_nxt     = init_r;
    loc_nxt      = loc_r;
    largest_nxt  = largest_r;
    prev_ok_nxt  = prev_ok_r;
    prev_loc_nxt = prev_loc_r;
    prev_v_nxt   = prev_v_r;
    v_nxt        = v_r;
    nxt_rd_nxt   = nxt_rd_r;
    res_st_nxt   = res_st_r;
    res_pay_nxt  = res_pay_r;
    res_lf_nxt   = res_lf_r;
    rd_en        = 1'b0;
    rd_loc       = loc_r;
    wr_en        = 1'b0;
    wr_loc       = loc_r;
    wr_val       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          loc_nxt     = '0;
          largest_nxt = '0;
          prev_ok_nxt = 1'b0;
          res_st_nxt  = ST_OK;
          res_pay_nxt = '0;
          res_lf_nxt  = '0;
          state_nxt   = S_RD;
          if (in_req.op == OP_ALLOC) begin
            if (in_req.req_size < 0) begin
              res_st_nxt = ST_NEG;
              state_nxt  = S_DONE;
            end else if (in_req.req_size == 0) begin
              res_st_nxt = ST_ZERO;
              state_nxt  = S_DONE;
            end else if (!init_r) begin
              wr_en    = 1'b1;
              wr_loc   = '0;
              wr_val   = 16'(-(ARENA_BYTES - HDR));
              init_nxt = 1'b1;
            end
          end else begin
            if (in_req.block_offset > 16'(ARENA_BYTES)) begin
              res_st_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end else if (!init_r) begin
              res_st_nxt = ST_DBL_FREE;
              state_nxt  = S_DONE;
            end
          end
        end
      end
      S_RD: begin
        if (loc_r + LOC_W'(HDR) > LOC_W'(ARENA_BYTES)) begin
          res_st_nxt = (op_r == OP_ALLOC) ? ST_NO_SPACE : ST_BAD_START;
          res_lf_nxt = (op_r == OP_ALLOC) ? largest_r : '0;
          state_nxt  = S_DONE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (op_r == OP_ALLOC) begin
          if (rd_v < 0 && mag >= size_s) begin
            res_pay_nxt = 12'(loc_r + LOC_W'(HDR));
            wr_en       = 1'b1;
            if (rem >= LOC_W'(SPLIT_MIN)) begin
              wr_val    = size_r;
              state_nxt = S_SPLIT;
            end else begin
              wr_val    = 16'(mag);
              state_nxt = S_DONE;
            end
          end else begin
            if (rd_v < 0 && mag > LOC_W'(largest_r)) largest_nxt = 12'(mag);
            loc_nxt   = nxt;
            state_nxt = S_RD;
          end
        end else begin
          if (LOC_W'(addr_r) < nxt + LOC_W'(HDR)) begin
            if (rd_v < 0) begin
              res_st_nxt = ST_DBL_FREE;
              state_nxt  = S_DONE;
            end else if (LOC_W'(addr_r) != loc_r + LOC_W'(HDR)) begin
              res_st_nxt = ST_BAD_START;
              state_nxt  = S_DONE;
            end else begin
              v_nxt      = rd_v;
              nxt_rd_nxt = (nxt + LOC_W'(HDR) <= LOC_W'(ARENA_BYTES));
              rd_en      = nxt_rd_nxt;
              rd_loc     = nxt;
              state_nxt  = S_NEVAL;
            end
          end else begin
            prev_ok_nxt  = 1'b1;
            prev_loc_nxt = loc_r;
            prev_v_nxt   = rd_v;
            loc_nxt      = nxt;
            state_nxt    = S_RD;
          end
        end
      end
      S_SPLIT: begin
        wr_loc    = loc_r + LOC_W'(HDR) + size_s;
        wr_val    = 16'(-(rem - LOC_W'(HDR)));
        wr_en     = (wr_loc + LOC_W'(1) < LOC_W'(ARENA_BYTES));
        state_nxt = S_DONE;
      end
      S_NEVAL: begin
        wr_en = 1'b1;
        if (prev_ok_r && prev_v_r < 0) begin
          wr_loc = prev_loc_r;
          wr_val = 16'(pv_new);
        end else begin
          wr_loc = loc_r;
          wr_val = 16'(-merged);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_rsp.ready)) out_valid_r <= 1'b1;
      else if (out_rsp.ready) out_valid_r <= 1'b0;
    end
  end

  // S_SPLIT reads rem from the still-held read word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_req.op;
      size_r <= in_req.req_size;
      addr_r <= in_req.block_offset;
    end
    loc_r      <= loc_nxt;
    largest_r  <= largest_nxt;
    prev_ok_r  <= prev_ok_nxt;
    prev_loc_r <= prev_loc_nxt;
    prev_v_r   <= prev_v_nxt;
    v_r        <= v_nxt;
    nxt_rd_r   <= nxt_rd_nxt;
    res_st_r   <= res_st_nxt;
    res_pay_r  <= res_pay_nxt;
    res_lf_r   <= res_lf_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_rsp.ready)) begin
      out_st_r  <= res_st_r;
      out_pay_r <= res_pay_r;
      out_lf_r  <= res_lf_r;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_st_r;
  assign out_rsp.payload_offset = out_pay_r;
  assign out_rsp.largest_free   = out_lf_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_req.ready) else $error("accepted word left walker idle");
  a_pay_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status != ST_OK) |-> out_rsp.payload_offset == '0)
    else $error("payload on failed request");
  a_lf_only_nospace: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status != ST_NO_SPACE) |-> out_rsp.largest_free == '0)
    else $error("largest free on wrong status");

endmodule
